// ----- hdl/tow_pkg.sv -----
// tow_pkg: types, option kinds, byte offsets and CSR indexes for the TCP option walker.
// No dependencies; imported by tcp_option_walker and its checker.
package tow_pkg;

   typedef logic [7:0]  byte_type;
   typedef logic [5:0]  len_type;
   typedef logic [10:0] mss_type;
   typedef logic [2:0]  csr_index_type;
   typedef logic [15:0] csr_data_type;

   // Largest option area walked; a longer area_len saturates to this.
   localparam len_type MAX_AREA_BYTES = 6'd40;

   localparam byte_type KIND_END  = 8'd0;
   localparam byte_type KIND_PAD  = 8'd1;
   localparam byte_type KIND_MSS  = 8'd2;
   localparam byte_type KIND_SACK = 8'd4;
   localparam byte_type KIND_TS   = 8'd8;

   localparam logic [15:0] MSS_LOW_EXCL = 16'd536;
   localparam logic [15:0] MSS_HIGH     = 16'd1460;

   localparam len_type MSS_OPT_LEN     = 6'd4;
   localparam len_type FEC_MIN_LEN     = 6'd8;
   localparam byte_type MIN_OPT_LEN    = 8'd2;

   // Byte positions inside an option.
   localparam len_type OFS_VERSION  = 6'd2;
   localparam len_type OFS_DATA     = 6'd3;
   localparam len_type OFS_REPAIR   = 6'd4;
   localparam len_type OFS_SYM_HI   = 6'd6;
   localparam len_type OFS_SYM_LO   = 6'd7;

   typedef enum logic [2:0] {
      CSR_FEC_KIND     = 3'd0,
      CSR_FEC_LENGTH   = 3'd1,
      CSR_FEC_VERSION  = 3'd2,
      CSR_FEC_DATA     = 3'd3,
      CSR_FEC_REPAIR   = 3'd4,
      CSR_FEC_SYMLEN   = 3'd5
   } csr_reg_type;

   typedef struct packed {
      logic mss_valid;
      logic sack_ok;
      logic ts_seen;
      logic fec_ok;
      logic malformed;
      logic fec_body;   // FEC body fields matched in the current option
   } flags_type;

endpackage

// ----- hdl/tcp_option_walker.sv -----
// tcp_option_walker: walks a TCP option area one byte per request and reports found options.
// Depends on tow_pkg; checked by tow_checker (bound in tow_checker.sv).
//
//   channel  | direction | handshake               | payload
//   ---------+-----------+-------------------------+----------------------------------------
//   req      | in        | req_valid / req_ready   | opt_byte, first, area_len, last
//   rsp      | out       | rsp_valid / rsp_ready   | mss_value, mss_valid, sack_ok, ts_seen,
//            |           |                         | fec_ok, malformed
//   csr      | in        | csr_valid / csr_ready   | csr_index, csr_wdata
//
// One request per cycle. The walker state updates in the cycle a request is accepted;
// the result of a request with last set is in the rsp register on the next cycle.
// req_ready drops only while a result sits in the rsp register and rsp_ready is low.
// csr_ready is always high. Reset is synchronous; no clearing pass.
module tcp_option_walker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  tow_pkg::byte_type      req_opt_byte,
   input  logic                   req_first,
   input  tow_pkg::len_type       req_area_len,
   input  logic                   req_last,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output tow_pkg::mss_type       rsp_mss_value,
   output logic                   rsp_mss_valid,
   output logic                   rsp_sack_ok,
   output logic                   rsp_ts_seen,
   output logic                   rsp_fec_ok,
   output logic                   rsp_malformed,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  tow_pkg::csr_index_type csr_index,
   input  tow_pkg::csr_data_type  csr_wdata
);
   import tow_pkg::*;

   // configuration
   byte_type     cfg_kind_ff;
   len_type      cfg_length_ff;
   byte_type     cfg_version_ff;
   byte_type     cfg_data_ff;
   byte_type     cfg_repair_ff;
   csr_data_type cfg_symlen_ff;

   // walker state
   len_type   bytes_left_ff, bytes_left_in;
   len_type   offset_ff, offset_in;
   byte_type  kind_ff, kind_in;
   len_type   length_ff, length_in;
   logic      stopped_ff, stopped_in;
   byte_type  cap_ff [4];
   byte_type  cap_in [4];
   flags_type flags_ff, flags_in;
   mss_type   mss_ff, mss_in;

   // result register
   logic      rsp_valid_ff;
   mss_type   rsp_mss_ff;
   flags_type rsp_flags_ff;

   logic        req_fire;
   logic        finish;
   len_type     area_sat;
   logic [15:0] mss_word;
   logic [15:0] sym_word;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign area_sat  = (req_area_len > MAX_AREA_BYTES) ? MAX_AREA_BYTES : req_area_len;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_kind_ff    <= 8'd253;
         cfg_length_ff  <= 6'd8;
         cfg_version_ff <= 8'd1;
         cfg_data_ff    <= 8'd0;
         cfg_repair_ff  <= 8'd0;
         cfg_symlen_ff  <= 16'd0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_FEC_KIND:    cfg_kind_ff    <= csr_wdata[7:0];
            CSR_FEC_LENGTH:  cfg_length_ff  <= csr_wdata[5:0];
            CSR_FEC_VERSION: cfg_version_ff <= csr_wdata[7:0];
            CSR_FEC_DATA:    cfg_data_ff    <= csr_wdata[7:0];
            CSR_FEC_REPAIR:  cfg_repair_ff  <= csr_wdata[7:0];
            CSR_FEC_SYMLEN:  cfg_symlen_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      bytes_left_in = bytes_left_ff;
      offset_in     = offset_ff;
      kind_in       = kind_ff;
      length_in     = length_ff;
      stopped_in    = stopped_ff;
      cap_in        = cap_ff;
      flags_in      = flags_ff;
      mss_in        = mss_ff;
      finish        = 1'b0;
      mss_word      = 16'd0;
      sym_word      = 16'd0;

      if (req_first) begin
         bytes_left_in = area_sat;
         offset_in     = '0;
         kind_in       = '0;
         length_in     = '0;
         stopped_in    = 1'b0;
         cap_in        = '{default: '0};
         flags_in      = '0;
         mss_in        = '0;
      end

      if (!stopped_in && bytes_left_in != '0) begin
         if (offset_in == '0) begin
            flags_in.fec_body = 1'b0;
            if (req_opt_byte == KIND_END) begin
               stopped_in = 1'b1;
            end else if (req_opt_byte == KIND_PAD) begin
               bytes_left_in = bytes_left_in - 6'd1;
            end else if (bytes_left_in < 6'd2) begin
               // kind with no room for its length byte
               flags_in.malformed = 1'b1;
               stopped_in         = 1'b1;
            end else begin
               kind_in       = req_opt_byte;
               offset_in     = 6'd1;
               bytes_left_in = bytes_left_in - 6'd1;
            end
         end else if (offset_in == 6'd1) begin
            if (req_opt_byte < MIN_OPT_LEN ||
                {1'b0, req_opt_byte} > ({3'b000, bytes_left_in} + 9'd1)) begin
               flags_in.malformed = 1'b1;
               stopped_in         = 1'b1;
            end else begin
               length_in     = req_opt_byte[5:0];
               offset_in     = 6'd2;
               bytes_left_in = bytes_left_in - 6'd1;
               finish        = (req_opt_byte == MIN_OPT_LEN);
            end
         end else begin
            sym_word = {cap_in[3], req_opt_byte};
            case (offset_in)
               OFS_VERSION: cap_in[0] = req_opt_byte;
               OFS_DATA:    cap_in[1] = req_opt_byte;
               OFS_REPAIR:  cap_in[2] = req_opt_byte;
               OFS_SYM_HI:  cap_in[3] = req_opt_byte;
               OFS_SYM_LO: begin
                  if (cap_in[0] == cfg_version_ff && cap_in[1] == cfg_data_ff &&
                      cap_in[2] == cfg_repair_ff && sym_word == cfg_symlen_ff)
                     flags_in.fec_body = 1'b1;
               end
               default: ;
            endcase
            bytes_left_in = bytes_left_in - 6'd1;
            offset_in     = offset_in + 6'd1;
            finish        = (offset_in >= length_in);
         end
      end

      if (finish) begin
         mss_word  = {cap_in[0], cap_in[1]};
         offset_in = '0;
         if (kind_in == KIND_MSS) begin
            if (length_in == MSS_OPT_LEN && mss_word > MSS_LOW_EXCL && mss_word <= MSS_HIGH) begin
               mss_in             = mss_word[10:0];
               flags_in.mss_valid = 1'b1;
            end
         end else if (kind_in == KIND_SACK) begin
            flags_in.sack_ok = 1'b1;
         end else if (kind_in == KIND_TS) begin
            flags_in.ts_seen = 1'b1;
         end else if (kind_in == cfg_kind_ff) begin
            if (length_in == cfg_length_ff && length_in >= FEC_MIN_LEN && flags_in.fec_body)
               flags_in.fec_ok = 1'b1;
         end
      end

      if (req_last) begin
         stopped_in    = 1'b1;
         bytes_left_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_left_ff <= '0;
         offset_ff     <= '0;
         kind_ff       <= '0;
         length_ff     <= '0;
         stopped_ff    <= 1'b0;
         cap_ff        <= '{default: '0};
         flags_ff      <= '0;
         mss_ff        <= '0;
      end else if (req_fire) begin
         bytes_left_ff <= bytes_left_in;
         offset_ff     <= offset_in;
         kind_ff       <= kind_in;
         length_ff     <= length_in;
         stopped_ff    <= stopped_in;
         cap_ff        <= cap_in;
         flags_ff      <= flags_in;
         mss_ff        <= mss_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire && req_last) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && req_last) begin
         rsp_flags_ff <= flags_in;
         rsp_mss_ff   <= flags_in.mss_valid ? mss_in : '0;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_mss_value = rsp_mss_ff;
   assign rsp_mss_valid = rsp_flags_ff.mss_valid;
   assign rsp_sack_ok   = rsp_flags_ff.sack_ok;
   assign rsp_ts_seen   = rsp_flags_ff.ts_seen;
   assign rsp_fec_ok    = rsp_flags_ff.fec_ok;
   assign rsp_malformed = rsp_flags_ff.malformed;

endmodule

// ----- hdl/tow_checker.sv -----
// tow_checker: port-level assertions for tcp_option_walker, plus the bind that attaches them.
// Depends on tow_pkg and the tcp_option_walker port list.
module tow_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             req_last,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input tow_pkg::mss_type rsp_mss_value,
   input logic             rsp_mss_valid,
   input logic             rsp_sack_ok,
   input logic             rsp_ts_seen,
   input logic             rsp_fec_ok,
   input logic             rsp_malformed
);
   import tow_pkg::*;

   // a stalled result keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid &&
      $stable({rsp_mss_value, rsp_mss_valid, rsp_sack_ok, rsp_ts_seen,
               rsp_fec_ok, rsp_malformed}))
      else $error("rsp changed while stalled");

   // a request closing an area yields a result next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last |=> rsp_valid)
      else $error("no result after last request");

   // a mid-area request never produces a result
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_last && (!rsp_valid || rsp_ready) |=> !rsp_valid)
      else $error("result without last request");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_mss_valid |->
      {5'd0, rsp_mss_value} > MSS_LOW_EXCL && {5'd0, rsp_mss_value} <= MSS_HIGH)
      else $error("MSS out of accepted range");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_mss_valid |-> rsp_mss_value == '0)
      else $error("MSS value without mss_valid");

endmodule

bind tcp_option_walker tow_checker u_tow_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .req_last      (req_last),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_mss_value (rsp_mss_value),
   .rsp_mss_valid (rsp_mss_valid),
   .rsp_sack_ok   (rsp_sack_ok),
   .rsp_ts_seen   (rsp_ts_seen),
   .rsp_fec_ok    (rsp_fec_ok),
   .rsp_malformed (rsp_malformed)
);
